FILE: sv/fali_pkg.sv
// shared types, constants and helpers of the five-axis line interpolator
`default_nettype none

package fali_pkg;

	localparam int COORD_BITS = 16;
	localparam int NUM_AXES   = 5;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 3;

	// stream widths, fields packed from bit 0 and padded to whole bytes
	localparam int IN_FIELD_BITS  = 2 * NUM_AXES * COORD_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * NUM_AXES + NUM_AXES * COORD_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	// axis indexes, also the bit order of the masks
	localparam logic [2:0] AX_X = 3'd0;
	localparam logic [2:0] AX_Y = 3'd1;
	localparam logic [2:0] AX_Z = 3'd2;
	localparam logic [2:0] AX_A = 3'd3;
	localparam logic [2:0] AX_C = 3'd4;

	// request kinds carried on the input tuser bit
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DELTA_BITS-1:0]        delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [NUM_AXES-1:0]          axis_mask_t;
	typedef logic [2:0]                   axis_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_XYZ  = 2'd1,
		PH_AC   = 2'd2
	} phase_t;

	typedef struct packed {
		coord_t [NUM_AXES-1:0] pos;
		delta_t [NUM_AXES-1:0] delta;
		axis_mask_t            dir;
		logic [1:0]            xyz_drv;
		logic                  ac_drv;
		delta_t                remain;
		err_t                  err_first;
		err_t                  err_second;
		err_t                  err_rotary;
		phase_t                phase;
	} interp_state_t;

	typedef struct packed {
		axis_mask_t            step_mask;
		axis_mask_t            dir_mask;
		coord_t [NUM_AXES-1:0] pos;
		logic                  last;
	} step_result_t;

	// one unit step with wraparound at the coordinate width
	function automatic coord_t step_coord(coord_t p, logic up);
		return up ? coord_t'(p + coord_t'(1)) : coord_t'(p - coord_t'(1));
	endfunction

	function automatic err_t twice(delta_t d);
		return $signed({1'b0, d, 1'b0});
	endfunction

	function automatic err_t widen(delta_t d);
		return $signed({2'b00, d});
	endfunction

endpackage

`default_nettype wire

FILE: sv/five_axis_line_interpolator_core.sv
// top level of the five-axis line interpolator
`default_nettype none

// Five-axis line interpolator. A load request (tuser = 0) sets up a move from
// the start point to the end point and gives no result; each tick request
// (tuser = 1) makes one Bresenham step and gives one result with the stepped
// axes, the move directions and the new position. All x/y/z steps come first
// with a and c held, then the a/c steps; tlast marks the final step of the
// move. Ticks while idle are dropped, and a load aborts a running move.
// The block takes one request per clock while the output register has room for
// its result: a request sits in the input register, is resolved in a single pass
// of add and compare logic against the move state, and lands in the output
// register. The throughput limit is the state update loop (position, error
// terms, step count), which closes through the move state register.
// A full output register only holds back tick requests that would produce a
// result; loads and idle ticks still pass.

module five_axis_line_interpolator_core import fali_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	// request side
	input  wire                      s_axis_tvalid,
	output logic                     s_axis_tready,
	// start_x, start_y, start_z, start_a, start_c, end_x, end_y, end_z, end_a, end_c
	input  wire  [IN_DATA_BITS-1:0]  s_axis_tdata,
	// cmd
	input  wire  [0:0]               s_axis_tuser,
	// result side
	output logic                     m_axis_tvalid,
	input  wire                      m_axis_tready,
	// step_mask, dir_mask, pos_x_out, pos_y_out, pos_z_out, pos_a_out, pos_c_out
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	output logic                     m_axis_tlast
);

	// input register
	logic                     req_valid_s1;
	logic                     cmd_s1;
	logic [IN_DATA_BITS-1:0]  data_s1;

	// move state and output register
	interp_state_t            state_q;
	step_result_t             res_q;
	logic                     out_valid_q;

	// step stage
	coord_t                   start_pt [NUM_AXES];
	coord_t                   end_pt   [NUM_AXES];
	interp_state_t            state_nxt;
	step_result_t             res_nxt;
	logic                     produce;
	logic                     out_free;
	logic                     advance;

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			start_pt[k] = data_s1[k*COORD_BITS +: COORD_BITS];
			end_pt[k]   = data_s1[(NUM_AXES+k)*COORD_BITS +: COORD_BITS];
		end
	end

	fali_step u_step (
		.cur      (state_q),
		.cmd      (cmd_s1),
		.start_pt (start_pt),
		.end_pt   (end_pt),
		.nxt      (state_nxt),
		.res      (res_nxt),
		.produce  (produce)
	);

	// a request resolves now unless its result has nowhere to go
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = req_valid_s1 && (out_free || !produce);
	assign s_axis_tready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
			state_q      <= '0;
		end else begin
			if (s_axis_tready) begin
				req_valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= advance && produce;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser[0];
			data_s1 <= s_axis_tdata;
		end
		if (advance && produce) begin
			res_q <= res_nxt;
		end
	end

	// pack the result, zero padding above the fields
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[NUM_AXES-1:0]          = res_q.step_mask;
		m_axis_tdata[2*NUM_AXES-1:NUM_AXES] = res_q.dir_mask;
		for (int k = 0; k < NUM_AXES; k++) begin
			m_axis_tdata[2*NUM_AXES + k*COORD_BITS +: COORD_BITS] = res_q.pos[k];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = res_q.last;

endmodule

`default_nettype wire

FILE: sv/fali_step.sv
// next-state and result logic for one load or tick request
`default_nettype none

module fali_step import fali_pkg::*; (
	input  interp_state_t cur,
	input  logic          cmd,
	input  coord_t        start_pt [NUM_AXES],
	input  coord_t        end_pt   [NUM_AXES],
	output interp_state_t nxt,
	output step_result_t  res,
	output logic          produce
);

	delta_t     ld_delta [NUM_AXES];
	axis_mask_t ld_dir;
	logic [1:0] ld_xyz;
	logic       ld_ac;
	axis_idx_t  ld_drv_i, ld_s1_i, ld_s2_i, ld_ac_i, ld_oth_i;
	delta_t     ld_xyz_d, ld_ac_d;

	axis_idx_t  drv_i, s1_i, s2_i, ac_i, oth_i;
	logic       remain_le1;
	logic       ac_nonzero;

	// per-axis delta and direction of a load
	always_comb begin
		logic signed [COORD_BITS:0] diff;
		for (int k = 0; k < NUM_AXES; k++) begin
			diff = (COORD_BITS+1)'(end_pt[k]) - (COORD_BITS+1)'(start_pt[k]);
			ld_delta[k] = diff[COORD_BITS] ? delta_t'(-diff) : delta_t'(diff);
			ld_dir[k]   = !diff[COORD_BITS] && (diff != '0);
		end
	end

	// driver choice, ties favor the lower axis
	always_comb begin
		if (ld_delta[0] >= ld_delta[1] && ld_delta[0] >= ld_delta[2]) begin
			ld_xyz = 2'd0;
		end else if (ld_delta[1] >= ld_delta[2]) begin
			ld_xyz = 2'd1;
		end else begin
			ld_xyz = 2'd2;
		end
		ld_ac    = !(ld_delta[3] >= ld_delta[4]);
		ld_drv_i = {1'b0, ld_xyz};
		ld_s1_i  = (ld_xyz == 2'd0) ? AX_Y : AX_X;
		ld_s2_i  = (ld_xyz == 2'd2) ? AX_Y : AX_Z;
		ld_ac_i  = ld_ac ? AX_C : AX_A;
		ld_oth_i = ld_ac ? AX_A : AX_C;
		ld_xyz_d = ld_delta[ld_drv_i];
		ld_ac_d  = ld_delta[ld_ac_i];
	end

	// axis roles of the running move
	always_comb begin
		drv_i      = {1'b0, cur.xyz_drv};
		s1_i       = (cur.xyz_drv == 2'd0) ? AX_Y : AX_X;
		s2_i       = (cur.xyz_drv == 2'd2) ? AX_Y : AX_Z;
		ac_i       = cur.ac_drv ? AX_C : AX_A;
		oth_i      = cur.ac_drv ? AX_A : AX_C;
		remain_le1 = (cur.remain <= delta_t'(1));
		ac_nonzero = (cur.delta[ac_i] != '0);
	end

	// phase sequencing, datapath and result
	always_comb begin
		axis_mask_t mask;
		logic       fin;
		nxt.phase      = cur.phase;
		nxt.pos        = cur.pos;
		nxt.delta      = cur.delta;
		nxt.dir        = cur.dir;
		nxt.xyz_drv    = cur.xyz_drv;
		nxt.ac_drv     = cur.ac_drv;
		nxt.remain     = cur.remain;
		nxt.err_first  = cur.err_first;
		nxt.err_second = cur.err_second;
		nxt.err_rotary = cur.err_rotary;
		mask           = '0;
		fin            = 1'b0;
		produce        = 1'b0;
		if (cmd == CMD_LOAD) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				nxt.pos[k]   = start_pt[k];
				nxt.delta[k] = ld_delta[k];
			end
			nxt.dir        = ld_dir;
			nxt.xyz_drv    = ld_xyz;
			nxt.ac_drv     = ld_ac;
			nxt.err_first  = twice(ld_delta[ld_s1_i]) - widen(ld_xyz_d);
			nxt.err_second = twice(ld_delta[ld_s2_i]) - widen(ld_xyz_d);
			nxt.err_rotary = twice(ld_delta[ld_oth_i]) - widen(ld_ac_d);
			nxt.remain     = (ld_xyz_d != '0) ? ld_xyz_d : ld_ac_d;
			if (ld_xyz_d != '0) begin
				nxt.phase = PH_XYZ;
			end else if (ld_ac_d != '0) begin
				nxt.phase = PH_AC;
			end else begin
				nxt.phase = PH_IDLE;
			end
		end else begin
			case (cur.phase)
				PH_XYZ: begin
					produce            = 1'b1;
					nxt.pos[drv_i]     = step_coord(cur.pos[drv_i], cur.dir[drv_i]);
					mask[drv_i]        = 1'b1;
					nxt.err_first      = cur.err_first + twice(cur.delta[s1_i]);
					nxt.err_second     = cur.err_second + twice(cur.delta[s2_i]);
					if (!cur.err_first[ERR_BITS-1]) begin
						nxt.pos[s1_i] = step_coord(cur.pos[s1_i], cur.dir[s1_i]);
						mask[s1_i]    = 1'b1;
						nxt.err_first = cur.err_first + twice(cur.delta[s1_i])
							- twice(cur.delta[drv_i]);
					end
					if (!cur.err_second[ERR_BITS-1]) begin
						nxt.pos[s2_i]  = step_coord(cur.pos[s2_i], cur.dir[s2_i]);
						mask[s2_i]     = 1'b1;
						nxt.err_second = cur.err_second + twice(cur.delta[s2_i])
							- twice(cur.delta[drv_i]);
					end
					if (remain_le1) begin
						nxt.remain = cur.delta[ac_i];
						nxt.phase  = ac_nonzero ? PH_AC : PH_IDLE;
						fin        = !ac_nonzero;
					end else begin
						nxt.remain = cur.remain - delta_t'(1);
					end
				end
				PH_AC: begin
					produce        = 1'b1;
					nxt.pos[ac_i]  = step_coord(cur.pos[ac_i], cur.dir[ac_i]);
					mask[ac_i]     = 1'b1;
					nxt.err_rotary = cur.err_rotary + twice(cur.delta[oth_i]);
					if (!cur.err_rotary[ERR_BITS-1]) begin
						nxt.pos[oth_i] = step_coord(cur.pos[oth_i], cur.dir[oth_i]);
						mask[oth_i]    = 1'b1;
						nxt.err_rotary = cur.err_rotary + twice(cur.delta[oth_i])
							- twice(cur.delta[ac_i]);
					end
					if (remain_le1) begin
						nxt.remain = '0;
						nxt.phase  = PH_IDLE;
						fin        = 1'b1;
					end else begin
						nxt.remain = cur.remain - delta_t'(1);
					end
				end
				default: produce = 1'b0;
			endcase
		end
		res.step_mask = mask;
		res.dir_mask  = cur.dir;
		res.pos       = nxt.pos;
		res.last      = fin;
	end

endmodule

`default_nettype wire

FILE: sv/fali_checker.sv
// port-level checks of the interpolator and their binding
`default_nettype none

module fali_checker import fali_pkg::*; (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     s_axis_tvalid,
	input wire                     s_axis_tready,
	input wire [0:0]               s_axis_tuser,
	input wire                     m_axis_tvalid,
	input wire                     m_axis_tready,
	input wire [OUT_DATA_BITS-1:0] m_axis_tdata,
	input wire                     m_axis_tlast
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// every result steps its driving axis at least
	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[NUM_AXES-1:0] != '0))
		else $error("result with empty step mask");

	// linear and rotary axes never step in the same result
	a_phase_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			!((|m_axis_tdata[2:0]) && (|m_axis_tdata[NUM_AXES-1:3])))
		else $error("linear and rotary steps mixed");

	// a load request that resolves into a free output register leaves it empty
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_LOAD))
			##1 (!m_axis_tvalid || m_axis_tready)
		|=> !m_axis_tvalid)
		else $error("result right after a load");

endmodule

bind five_axis_line_interpolator_core fali_checker u_fali_checker (.*);

`default_nettype wire

FILE: sim/tb_five_axis_line_interpolator_core.sv
// testbench for the five-axis line interpolator: predicted step results checked on the stream
`timescale 1ns / 100ps

module tb_five_axis_line_interpolator_core;
	import fali_pkg::*;

	localparam int     TOTAL_ITEMS   = 1850;
	localparam int     STALL_LIMIT   = 4000;
	localparam int     DRAIN_LIMIT   = 20000;
	localparam int     SETTLE_CYCLES = 8;
	localparam coord_t CMIN          = 16'sh8000;
	localparam coord_t CMAX          = 16'sh7fff;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
	logic [0:0]               s_axis_tuser = CMD_LOAD;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic                     m_axis_tlast;

	five_axis_line_interpolator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// tracked move state
	coord_t     trk_pos [NUM_AXES];
	int         trk_delta [NUM_AXES];
	axis_mask_t trk_dir;
	int         trk_lead3;
	int         trk_lead2;
	int         trk_left;
	int         trk_err1;
	int         trk_err2;
	int         trk_errr;
	phase_t     trk_phase = PH_IDLE;

	step_result_t expected_steps [$];

	int n_sent = 0;
	int n_loads = 0;
	int n_ticks = 0;
	int n_results = 0;
	int n_finished = 0;
	int n_errors = 0;
	bit steady = 1'b0;
	int stall_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [IN_DATA_BITS-1:0] rand_data();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic void minor_axes(input int lead, output int s1, output int s2);
		s1 = (lead == AX_X) ? AX_Y : AX_X;
		s2 = (lead == AX_Z) ? AX_Y : AX_Z;
	endfunction

	function automatic void step_axis(input int k);
		if (trk_dir[k]) trk_pos[k] = trk_pos[k] + 16'sd1;
		else trk_pos[k] = trk_pos[k] - 16'sd1;
	endfunction

	// ticks still needed to finish the tracked move
	function automatic int moves_left();
		if (trk_phase == PH_XYZ) return trk_left + trk_delta[trk_lead2];
		if (trk_phase == PH_AC) return trk_left;
		return 0;
	endfunction

	task automatic track_request(input logic cmd, input logic [IN_DATA_BITS-1:0] data);
		step_result_t want;
		int s1, s2, other;
		coord_t s_c, e_c;
		if (cmd == CMD_LOAD) begin
			n_loads++;
			trk_dir = '0;
			for (int k = 0; k < NUM_AXES; k++) begin
				s_c = data[COORD_BITS*k +: COORD_BITS];
				e_c = data[COORD_BITS*(NUM_AXES+k) +: COORD_BITS];
				trk_pos[k] = s_c;
				trk_delta[k] = (e_c > s_c) ? int'(e_c) - int'(s_c) : int'(s_c) - int'(e_c);
				if (e_c > s_c) trk_dir[k] = 1'b1;
			end
			if (trk_delta[AX_X] >= trk_delta[AX_Y] && trk_delta[AX_X] >= trk_delta[AX_Z])
				trk_lead3 = AX_X;
			else if (trk_delta[AX_Y] >= trk_delta[AX_Z])
				trk_lead3 = AX_Y;
			else
				trk_lead3 = AX_Z;
			trk_lead2 = (trk_delta[AX_A] >= trk_delta[AX_C]) ? AX_A : AX_C;
			minor_axes(trk_lead3, s1, s2);
			trk_err1 = 2 * trk_delta[s1] - trk_delta[trk_lead3];
			trk_err2 = 2 * trk_delta[s2] - trk_delta[trk_lead3];
			other = (trk_lead2 == AX_A) ? AX_C : AX_A;
			trk_errr = 2 * trk_delta[other] - trk_delta[trk_lead2];
			if (trk_delta[trk_lead3] > 0) begin
				trk_phase = PH_XYZ;
				trk_left = trk_delta[trk_lead3];
			end else if (trk_delta[trk_lead2] > 0) begin
				trk_phase = PH_AC;
				trk_left = trk_delta[trk_lead2];
			end else begin
				trk_phase = PH_IDLE;
				trk_left = 0;
			end
			return;
		end
		n_ticks++;
		// ticks while idle are dropped
		if (trk_phase == PH_IDLE) return;
		want.step_mask = '0;
		want.last = 1'b0;
		if (trk_phase == PH_XYZ) begin
			minor_axes(trk_lead3, s1, s2);
			step_axis(trk_lead3);
			want.step_mask[trk_lead3] = 1'b1;
			if (trk_err1 >= 0) begin
				step_axis(s1);
				want.step_mask[s1] = 1'b1;
				trk_err1 -= 2 * trk_delta[trk_lead3];
			end
			if (trk_err2 >= 0) begin
				step_axis(s2);
				want.step_mask[s2] = 1'b1;
				trk_err2 -= 2 * trk_delta[trk_lead3];
			end
			trk_err1 += 2 * trk_delta[s1];
			trk_err2 += 2 * trk_delta[s2];
			trk_left--;
			if (trk_left <= 0) begin
				if (trk_delta[trk_lead2] > 0) begin
					trk_phase = PH_AC;
					trk_left = trk_delta[trk_lead2];
				end else begin
					trk_phase = PH_IDLE;
					trk_left = 0;
					want.last = 1'b1;
				end
			end
		end else begin
			other = (trk_lead2 == AX_A) ? AX_C : AX_A;
			step_axis(trk_lead2);
			want.step_mask[trk_lead2] = 1'b1;
			if (trk_errr >= 0) begin
				step_axis(other);
				want.step_mask[other] = 1'b1;
				trk_errr -= 2 * trk_delta[trk_lead2];
			end
			trk_errr += 2 * trk_delta[other];
			trk_left--;
			if (trk_left <= 0) begin
				trk_phase = PH_IDLE;
				trk_left = 0;
				want.last = 1'b1;
			end
		end
		want.dir_mask = trk_dir;
		for (int k = 0; k < NUM_AXES; k++) want.pos[k] = trk_pos[k];
		expected_steps.push_back(want);
	endtask

	// one request; tvalid stays high into the next request when there is no gap
	task automatic send_request(input logic cmd, input logic [IN_DATA_BITS-1:0] data);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		track_request(cmd, data);
		n_sent++;
	endtask

	task automatic send_load(input coord_t st [NUM_AXES], input coord_t en [NUM_AXES]);
		logic [IN_DATA_BITS-1:0] data;
		data = '0;
		for (int k = 0; k < NUM_AXES; k++) begin
			data[COORD_BITS*k +: COORD_BITS] = st[k];
			data[COORD_BITS*(NUM_AXES+k) +: COORD_BITS] = en[k];
		end
		send_request(CMD_LOAD, data);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_request(CMD_TICK, rand_data());
	endtask

	// hold the request side until every predicted step has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_steps.size() != 0);
	endtask

	// small move around a random start, axes often equal or tied
	task automatic send_small_move(input int reach);
		coord_t st [NUM_AXES];
		coord_t en [NUM_AXES];
		int off, e;
		for (int k = 0; k < NUM_AXES; k++) begin
			st[k] = coord_t'($urandom);
			off = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, reach);
			if ($urandom_range(0, 1)) off = -off;
			e = int'(st[k]) + off;
			if (e > int'(CMAX) || e < int'(CMIN)) e = int'(st[k]) - off;
			en[k] = coord_t'(e);
		end
		send_load(st, en);
	endtask

	task automatic test_idle_ticks();
		send_ticks(2);
	endtask

	task automatic test_corner_moves();
		coord_t st [NUM_AXES];
		coord_t en [NUM_AXES];
		// full range upward, all deltas tied, then aborted by the next load
		st = '{CMIN, CMIN, CMIN, CMIN, CMIN};
		en = '{CMAX, CMAX, CMAX, CMAX, CMAX};
		send_load(st, en);
		send_ticks(2);
		// full range downward
		send_load(en, st);
		send_ticks(2);
		// no motion on any axis, block stays idle
		st = '{CMAX, CMIN, 16'sd0, 16'sd1234, -16'sd77};
		send_load(st, st);
		send_ticks(1);
		// no 3D motion, goes straight to the a/c line
		st = '{16'sd5, 16'sd5, 16'sd5, 16'sd100, -16'sd100};
		en = '{16'sd5, 16'sd5, 16'sd5, 16'sd103, -16'sd101};
		send_load(st, en);
		send_ticks(3);
		// y and z tie on the 3D line, c leads the 2D line, extra idle tick
		st = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
		en = '{16'sd1, -16'sd3, 16'sd3, 16'sd1, -16'sd2};
		send_load(st, en);
		send_ticks(6);
		// z leads
		st = '{-16'sd10, 16'sd7, 16'sd300, 16'sd0, 16'sd0};
		en = '{-16'sd9, 16'sd7, 16'sd298, 16'sd0, 16'sd0};
		send_load(st, en);
		send_ticks(2);
	endtask

	task automatic test_drain_pause();
		send_small_move(6);
		send_ticks(moves_left() / 2);
		wait_drained();
		send_ticks(moves_left());
		wait_drained();
	endtask

	task automatic test_random_moves();
		int pick, n;
		while (n_sent < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) steady = 1'b1;
			else if (pick < 12) steady = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				send_small_move(($urandom_range(0, 7) == 0) ? 40 : 12);
				n = moves_left();
				if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 2);
				send_ticks(n);
			end else if (pick < 84) begin
				send_small_move(12);
				send_ticks($urandom_range(0, moves_left()));
			end else if (pick < 92) begin
				send_request(CMD_LOAD, rand_data());
				send_ticks($urandom_range(1, 8));
			end else begin
				repeat ($urandom_range(1, 4))
					send_request($urandom_range(0, 3) == 0 ? CMD_LOAD : CMD_TICK, rand_data());
			end
			if ($urandom_range(0, 29) == 0) wait_drained();
		end
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 9) < 3) begin
			m_axis_tready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_steps.size() == 0) begin
				$display("%0t: unexpected step result, expected none, got tdata %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				n_errors++;
			end else begin
				want = expected_steps.pop_front();
				n_results++;
				if (want.last) n_finished++;
				check_field("step_mask", want.step_mask, m_axis_tdata[4:0]);
				check_field("dir_mask", want.dir_mask, m_axis_tdata[9:5]);
				for (int k = 0; k < NUM_AXES; k++)
					check_field($sformatf("pos[%0d]", k), $signed(want.pos[k]),
						$signed(m_axis_tdata[2*NUM_AXES + COORD_BITS*k +: COORD_BITS]));
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
			else quiet++;
		end
		$display("%0t: watchdog, no handshake for %0d cycles", $time, quiet);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_corner_moves();
		test_drain_pause();
		test_random_moves();
		s_axis_tvalid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (expected_steps.size() != 0 && waited < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_steps.size() != 0) begin
			$display("%0t: %0d expected step results never arrived", $time, expected_steps.size());
			n_errors++;
		end
		$display("sent %0d loads and %0d ticks; checked %0d step results, %0d moves to the end",
			n_loads, n_ticks, n_results, n_finished);
		$display("%0d mismatches found", n_errors);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
sv/fali_pkg.sv
sv/fali_step.sv
sv/five_axis_line_interpolator_core.sv
sv/fali_checker.sv
sim/tb_five_axis_line_interpolator_core.sv
